// ===== hw/rtl/cpu8_execute_unit_assert.svh =====
// Assertion macros used by the execute unit back end.
`ifndef CPU8_EXECUTE_UNIT_ASSERT_SVH
`define CPU8_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPU8EU_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cpu8 execute unit: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CPU8EU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cpu8 execute unit: check failed");

`endif

// ===== hw/rtl/cpu8eu_pkg.sv =====
package cpu8eu_pkg;

	// Default size of the internal stack page.
	localparam int STACK_BYTES_DEF = 256;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Status bit positions: N V - B D I Z C.
	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	// Bits 5 and 4 as seen on a pushed status byte.
	localparam logic [7:0] PUSH_MASK = 8'h30;

	localparam logic [7:0] SP_RESET = 8'hFF;
	localparam logic [7:0] P_RESET  = 8'h04;

	typedef enum logic [5:0] {
		ACT_CLC = 6'd0,  ACT_CLD = 6'd1,  ACT_CLI = 6'd2,  ACT_CLV = 6'd3,
		ACT_SEC = 6'd4,  ACT_SED = 6'd5,  ACT_SEI = 6'd6,
		ACT_LDA = 6'd7,  ACT_LDX = 6'd8,  ACT_LDY = 6'd9,
		ACT_STA = 6'd10, ACT_STX = 6'd11, ACT_STY = 6'd12,
		ACT_TAX = 6'd13, ACT_TAY = 6'd14, ACT_TSX = 6'd15,
		ACT_TXA = 6'd16, ACT_TXS = 6'd17, ACT_TYA = 6'd18,
		ACT_PHA = 6'd19, ACT_PHP = 6'd20, ACT_PLA = 6'd21, ACT_PLP = 6'd22,
		ACT_ASL = 6'd23, ACT_LSR = 6'd24, ACT_ROL = 6'd25, ACT_ROR = 6'd26,
		ACT_AND = 6'd27, ACT_EOR = 6'd28, ACT_ORA = 6'd29, ACT_BIT = 6'd30,
		ACT_INC = 6'd31, ACT_DEC = 6'd32,
		ACT_INX = 6'd33, ACT_INY = 6'd34, ACT_DEX = 6'd35, ACT_DEY = 6'd36,
		ACT_BCC = 6'd37, ACT_BCS = 6'd38, ACT_BEQ = 6'd39, ACT_BNE = 6'd40,
		ACT_BMI = 6'd41, ACT_BPL = 6'd42, ACT_BVC = 6'd43, ACT_BVS = 6'd44,
		ACT_JMP = 6'd45, ACT_JSR = 6'd46, ACT_RTS = 6'd47, ACT_BRK = 6'd48,
		ACT_RTI = 6'd49, ACT_NOP = 6'd50
	} act_t;

	typedef struct packed {
		logic [5:0]  action;
		logic [7:0]  operand;
		logic [15:0] effective_address;
		logic        on_accumulator;
		logic [15:0] next_pc;
	} in_item_t;

	typedef struct packed {
		logic [15:0] new_pc;
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [7:0]  acc_value;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [7:0]  stack_pointer;
		logic [7:0]  flags;
	} out_item_t;

	// Classified instruction as it travels through the queue.
	typedef struct packed {
		act_t        act;
		logic [1:0]  last_step;
		logic [7:0]  operand;
		logic [15:0] ea;
		logic        on_acc;
		logic [15:0] npc;
	} dec_t;

endpackage

// ===== hw/rtl/cpu8eu_chan_if.sv =====
interface cpu8eu_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpu8eu_front.sv =====
module cpu8eu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	cpu8eu_chan_if.sink          instr,
	output logic                 q_valid,
	input  logic                 q_ready,
	output cpu8eu_pkg::dec_t     q_data
);
	import cpu8eu_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dec_t            queue_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	dec_t            dec;
	logic            push;
	logic            pop;

	// Classify the incoming instruction: unknown codes become NOP, and the
	// number of stack steps is worked out here.
	always_comb begin
		dec.operand = instr.data.operand;
		dec.ea      = instr.data.effective_address;
		dec.on_acc  = instr.data.on_accumulator;
		dec.npc     = instr.data.next_pc;
		if (instr.data.action > ACT_NOP) begin
			dec.act = ACT_NOP;
		end else begin
			dec.act = act_t'(instr.data.action);
		end
		unique case (dec.act)
			ACT_PLA, ACT_PLP, ACT_JSR: dec.last_step = 2'd1;
			ACT_RTS, ACT_BRK:          dec.last_step = 2'd2;
			ACT_RTI:                   dec.last_step = 2'd3;
			default:                   dec.last_step = 2'd0;
		endcase
	end

	assign instr.ready = (count_q != CW'(QUEUE_DEPTH));
	assign push        = instr.valid && instr.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_valid && q_ready;
	assign q_data      = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/cpu8eu_back.sv =====
module cpu8eu_back #(
	parameter int STACK_BYTES = cpu8eu_pkg::STACK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  cpu8eu_pkg::dec_t     q_data,
	cpu8eu_chan_if.sink          cfg,
	cpu8eu_chan_if.source        result
);
	import cpu8eu_pkg::*;
	`include "cpu8_execute_unit_assert.svh"

	localparam int AW = $clog2(STACK_BYTES);

	// Stack pointer to stack entry, reduced modulo the page size.
	function automatic logic [256*AW-1:0] build_idx();
		logic [256*AW-1:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[i*AW +: AW] = AW'(i % STACK_BYTES);
		end
		return t;
	endfunction

	localparam logic [256*AW-1:0] IdxTab = build_idx();

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r       = p;
		r[FL_N] = v[7];
		r[FL_Z] = (v == 8'h00);
		return r;
	endfunction

	logic [7:0]  stk_mem [STACK_BYTES];
	logic [7:0]  rd_q;
	logic [7:0]  a_q, x_q, y_q, sp_q, p_q, lo_q;
	logic [15:0] bv_q;
	dec_t        cur_q;
	logic        cur_v_q;
	logic [1:0]  step_q;
	out_item_t   out_q;
	logic        out_v_q;

	logic [7:0]    n_a, n_x, n_y, n_sp, n_p, n_lo;
	logic [7:0]    sp_inc, src, res, mem_wd, wd;
	logic [AW-1:0] wr_idx, rd_idx;
	logic          mem_we, mem_re, we, take, final_step, out_free, go, load;
	logic [15:0]   pc, ret;

	assign sp_inc     = sp_q + 8'd1;
	assign wr_idx     = IdxTab[int'(sp_q)*AW +: AW];
	assign rd_idx     = IdxTab[int'(sp_inc)*AW +: AW];
	assign final_step = (step_q == cur_q.last_step);
	assign out_free   = !out_v_q || result.ready;
	assign go         = cur_v_q && (!final_step || out_free);
	assign load       = go && final_step;
	assign q_ready    = !cur_v_q || load;
	assign ret        = cur_q.npc - 16'd1;
	assign cfg.ready  = 1'b1;

	// Execute the current step of the working instruction.
	always_comb begin
		n_a    = a_q;
		n_x    = x_q;
		n_y    = y_q;
		n_sp   = sp_q;
		n_p    = p_q;
		n_lo   = lo_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wd = 8'h00;
		we     = 1'b0;
		wd     = 8'h00;
		take   = 1'b0;
		pc     = cur_q.npc;
		src    = cur_q.on_acc ? a_q : cur_q.operand;
		res    = 8'h00;
		unique case (cur_q.act)
			ACT_CLC: n_p[FL_C] = 1'b0;
			ACT_CLD: n_p[FL_D] = 1'b0;
			ACT_CLI: n_p[FL_I] = 1'b0;
			ACT_CLV: n_p[FL_V] = 1'b0;
			ACT_SEC: n_p[FL_C] = 1'b1;
			ACT_SED: n_p[FL_D] = 1'b1;
			ACT_SEI: n_p[FL_I] = 1'b1;
			ACT_LDA: begin n_a = cur_q.operand; n_p = set_nz(p_q, n_a); end
			ACT_LDX: begin n_x = cur_q.operand; n_p = set_nz(p_q, n_x); end
			ACT_LDY: begin n_y = cur_q.operand; n_p = set_nz(p_q, n_y); end
			ACT_STA: begin we = 1'b1; wd = a_q; end
			ACT_STX: begin we = 1'b1; wd = x_q; end
			ACT_STY: begin we = 1'b1; wd = y_q; end
			ACT_TAX: begin n_x = a_q; n_p = set_nz(p_q, n_x); end
			ACT_TAY: begin n_y = a_q; n_p = set_nz(p_q, n_y); end
			ACT_TSX: begin n_x = sp_q; n_p = set_nz(p_q, n_x); end
			ACT_TXA: begin n_a = x_q; n_p = set_nz(p_q, n_a); end
			ACT_TXS: n_sp = x_q;
			ACT_TYA: begin n_a = y_q; n_p = set_nz(p_q, n_a); end
			ACT_PHA: begin mem_we = 1'b1; mem_wd = a_q; n_sp = sp_q - 8'd1; end
			ACT_PHP: begin
				mem_we = 1'b1;
				mem_wd = p_q | PUSH_MASK;
				n_sp   = sp_q - 8'd1;
			end
			ACT_PLA, ACT_PLP: begin
				if (step_q == 2'd0) begin
					mem_re = 1'b1;
					n_sp   = sp_inc;
				end else if (cur_q.act == ACT_PLA) begin
					n_a = rd_q;
					n_p = set_nz(p_q, rd_q);
				end else begin
					n_p = rd_q & ~PUSH_MASK;
				end
			end
			ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR: begin
				unique case (cur_q.act)
					ACT_ASL: begin res = {src[6:0], 1'b0};      n_p[FL_C] = src[7]; end
					ACT_LSR: begin res = {1'b0, src[7:1]};      n_p[FL_C] = src[0]; end
					ACT_ROL: begin res = {src[6:0], p_q[FL_C]}; n_p[FL_C] = src[7]; end
					default: begin res = {p_q[FL_C], src[7:1]}; n_p[FL_C] = src[0]; end
				endcase
				n_p = set_nz(n_p, res);
				if (cur_q.on_acc) begin
					n_a = res;
				end else begin
					we = 1'b1;
					wd = res;
				end
			end
			ACT_AND: begin n_a = a_q & cur_q.operand; n_p = set_nz(p_q, n_a); end
			ACT_EOR: begin n_a = a_q ^ cur_q.operand; n_p = set_nz(p_q, n_a); end
			ACT_ORA: begin n_a = a_q | cur_q.operand; n_p = set_nz(p_q, n_a); end
			ACT_BIT: begin
				n_p[FL_N] = cur_q.operand[7];
				n_p[FL_V] = cur_q.operand[6];
				n_p[FL_Z] = ((a_q & cur_q.operand) == 8'h00);
			end
			ACT_INC: begin we = 1'b1; wd = cur_q.operand + 8'd1; n_p = set_nz(p_q, wd); end
			ACT_DEC: begin we = 1'b1; wd = cur_q.operand - 8'd1; n_p = set_nz(p_q, wd); end
			ACT_INX: begin n_x = x_q + 8'd1; n_p = set_nz(p_q, n_x); end
			ACT_INY: begin n_y = y_q + 8'd1; n_p = set_nz(p_q, n_y); end
			ACT_DEX: begin n_x = x_q - 8'd1; n_p = set_nz(p_q, n_x); end
			ACT_DEY: begin n_y = y_q - 8'd1; n_p = set_nz(p_q, n_y); end
			ACT_BCC: take = !p_q[FL_C];
			ACT_BCS: take = p_q[FL_C];
			ACT_BEQ: take = p_q[FL_Z];
			ACT_BNE: take = !p_q[FL_Z];
			ACT_BMI: take = p_q[FL_N];
			ACT_BPL: take = !p_q[FL_N];
			ACT_BVC: take = !p_q[FL_V];
			ACT_BVS: take = p_q[FL_V];
			ACT_JMP: pc = cur_q.ea;
			ACT_JSR: begin
				mem_we = 1'b1;
				n_sp   = sp_q - 8'd1;
				mem_wd = (step_q == 2'd0) ? ret[15:8] : ret[7:0];
				pc     = cur_q.ea;
			end
			ACT_BRK: begin
				mem_we = 1'b1;
				n_sp   = sp_q - 8'd1;
				pc     = bv_q;
				priority case (step_q)
					2'd0:    mem_wd = cur_q.npc[15:8];
					2'd1:    mem_wd = cur_q.npc[7:0];
					default: begin
						mem_wd    = p_q | PUSH_MASK;
						n_p[FL_I] = 1'b1;
					end
				endcase
			end
			ACT_RTS: begin
				pc = {rd_q, lo_q} + 16'd1;
				if (step_q != 2'd2) begin
					mem_re = 1'b1;
					n_sp   = sp_inc;
				end
				if (step_q == 2'd1) begin
					n_lo = rd_q;
				end
			end
			ACT_RTI: begin
				pc = {rd_q, lo_q};
				if (step_q != 2'd3) begin
					mem_re = 1'b1;
					n_sp   = sp_inc;
				end
				if (step_q == 2'd1) begin
					n_p = rd_q & ~PUSH_MASK;
				end
				if (step_q == 2'd2) begin
					n_lo = rd_q;
				end
			end
			default: ;
		endcase
		if (take) begin
			pc = cur_q.npc + {{8{cur_q.operand[7]}}, cur_q.operand};
		end
		mem_we = mem_we && go;
		mem_re = mem_re && go;
	end

	// Stack page: one port, write or registered read each cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stk_mem[wr_idx] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= stk_mem[rd_idx];
		end
	end

	// Working instruction and its step count.
	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			cur_q <= q_data;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.new_pc        <= pc;
			out_q.write_enable  <= we;
			out_q.write_address <= we ? cur_q.ea : 16'h0000;
			out_q.write_data    <= we ? wd : 8'h00;
			out_q.acc_value     <= n_a;
			out_q.x_value       <= n_x;
			out_q.y_value       <= n_y;
			out_q.stack_pointer <= n_sp;
			out_q.flags         <= n_p;
		end
	end

	// Architectural registers and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= 8'h00;
			x_q     <= 8'h00;
			y_q     <= 8'h00;
			sp_q    <= SP_RESET;
			p_q     <= P_RESET;
			lo_q    <= 8'h00;
			bv_q    <= 16'h0000;
			cur_v_q <= 1'b0;
			step_q  <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				bv_q <= cfg.data;
			end
			if (go) begin
				a_q  <= n_a;
				x_q  <= n_x;
				y_q  <= n_y;
				sp_q <= n_sp;
				p_q  <= n_p;
				lo_q <= n_lo;
				step_q <= final_step ? 2'd0 : step_q + 2'd1;
			end
			if (q_ready) begin
				cur_v_q <= q_valid;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	// The single stack port never reads and writes in one cycle.
	`CPU8EU_ASSERT_NOW(a_stk_port, clk, arst_n, mem_we, !mem_re)
	// The step counter never runs past the last step of an instruction.
	`CPU8EU_ASSERT_NOW(a_step_range, clk, arst_n, cur_v_q, step_q <= cur_q.last_step)
	// A stack read always moves the pointer up by one.
	`CPU8EU_ASSERT_NEXT(a_pull_sp, clk, arst_n, mem_re, sp_q == $past(sp_q) + 8'd1)
	// A stalled result is not overwritten.
	`CPU8EU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_v_q && !result.ready, $stable(out_q))

endmodule

// ===== hw/rtl/cpu8_execute_unit.sv =====
// Each instruction passes the queue, the working instruction and the result register.
// Throughput: one instruction a cycle while results are taken, PHA and PHP included;
// PLA, PLP, JSR, RTS, BRK, RTI run in steps, as the stack memory has a single port.
// A two-entry queue lets the front keep taking transfers while the back is busy.
// Reset: asynchronous, active low; A, X, Y clear, SP becomes 0xFF, status 0x04,
// break vector 0; the stack page holds no defined contents until written.
module cpu8_execute_unit #(
	parameter int STACK_BYTES = cpu8eu_pkg::STACK_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cpu8eu_chan_if.sink   instr,
	cpu8eu_chan_if.sink   cfg,
	cpu8eu_chan_if.source result
);
	import cpu8eu_pkg::*;

	logic q_valid;
	logic q_ready;
	dec_t q_data;

	// Front: accept and classify.
	cpu8eu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	// Back: execute, stack and result register.
	cpu8eu_back #(
		.STACK_BYTES (STACK_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.cfg     (cfg),
		.result  (result)
	);

endmodule

// ===== dv/tb_cpu8_execute_unit.sv =====
module tb_cpu8_execute_unit;
	import cpu8eu_pkg::*;

	logic clk;
	logic arst_n;

	cpu8eu_chan_if #(.T(in_item_t))    instr_ch ();
	cpu8eu_chan_if #(.T(logic [15:0])) cfg_ch ();
	cpu8eu_chan_if #(.T(out_item_t))   result_ch ();

	cpu8_execute_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	// Architectural state as the predictor sees it.
	logic [7:0]  acc_r, x_r, y_r, sp_r, p_r;
	logic [7:0]  stack_mem [256];
	bit          stack_known [256];
	logic [15:0] brk_vector;

	out_item_t   expected_results [$];
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned stack_ops;
	int unsigned vector_writes;
	bit          rx_idle_on;
	int          rx_hold;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t result;
	} stim_row_t;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void set_nz(logic [7:0] v);
		p_r[FL_N] = v[7];
		p_r[FL_Z] = (v == 8'h00);
	endfunction

	function automatic void stack_push(logic [7:0] v);
		stack_mem[sp_r] = v;
		stack_known[sp_r] = 1'b1;
		sp_r = sp_r - 8'd1;
	endfunction

	function automatic logic [7:0] stack_pull();
		sp_r = sp_r + 8'd1;
		return stack_mem[sp_r];
	endfunction

	// True when the next n pulls only touch entries already written.
	function automatic bit pulls_defined(int n);
		logic [7:0] idx;
		for (int i = 1; i <= n; i++) begin
			idx = sp_r + 8'(i);
			if (!stack_known[idx])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Execute one instruction on the shadow state and form its result.
	function automatic out_item_t execute_instr(in_item_t it);
		out_item_t   r;
		logic [7:0]  src, res, lo, hi, opd;
		logic [15:0] pc, ret;
		bit          we, take;
		logic [7:0]  wd;
		opd  = it.operand;
		pc   = it.next_pc;
		we   = 1'b0;
		take = 1'b0;
		wd   = 8'h00;
		case (act_t'(it.action))
			ACT_CLC: p_r[FL_C] = 1'b0;
			ACT_CLD: p_r[FL_D] = 1'b0;
			ACT_CLI: p_r[FL_I] = 1'b0;
			ACT_CLV: p_r[FL_V] = 1'b0;
			ACT_SEC: p_r[FL_C] = 1'b1;
			ACT_SED: p_r[FL_D] = 1'b1;
			ACT_SEI: p_r[FL_I] = 1'b1;
			ACT_LDA: begin acc_r = opd; set_nz(acc_r); end
			ACT_LDX: begin x_r = opd; set_nz(x_r); end
			ACT_LDY: begin y_r = opd; set_nz(y_r); end
			ACT_STA: begin we = 1'b1; wd = acc_r; end
			ACT_STX: begin we = 1'b1; wd = x_r; end
			ACT_STY: begin we = 1'b1; wd = y_r; end
			ACT_TAX: begin x_r = acc_r; set_nz(x_r); end
			ACT_TAY: begin y_r = acc_r; set_nz(y_r); end
			ACT_TSX: begin x_r = sp_r; set_nz(x_r); end
			ACT_TXA: begin acc_r = x_r; set_nz(acc_r); end
			ACT_TXS: sp_r = x_r;
			ACT_TYA: begin acc_r = y_r; set_nz(acc_r); end
			ACT_PHA: stack_push(acc_r);
			ACT_PHP: stack_push(p_r | PUSH_MASK);
			ACT_PLA: begin acc_r = stack_pull(); set_nz(acc_r); end
			ACT_PLP: p_r = stack_pull() & ~PUSH_MASK;
			ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR: begin
				src = it.on_accumulator ? acc_r : opd;
				case (act_t'(it.action))
					ACT_ASL: res = {src[6:0], 1'b0};
					ACT_LSR: res = {1'b0, src[7:1]};
					ACT_ROL: res = {src[6:0], p_r[FL_C]};
					default: res = {p_r[FL_C], src[7:1]};
				endcase
				p_r[FL_C] = (act_t'(it.action) == ACT_ASL ||
					act_t'(it.action) == ACT_ROL) ? src[7] : src[0];
				set_nz(res);
				if (it.on_accumulator)
					acc_r = res;
				else begin
					we = 1'b1;
					wd = res;
				end
			end
			ACT_AND: begin acc_r = acc_r & opd; set_nz(acc_r); end
			ACT_EOR: begin acc_r = acc_r ^ opd; set_nz(acc_r); end
			ACT_ORA: begin acc_r = acc_r | opd; set_nz(acc_r); end
			ACT_BIT: begin
				p_r[FL_N] = opd[7];
				p_r[FL_V] = opd[6];
				p_r[FL_Z] = ((acc_r & opd) == 8'h00);
			end
			ACT_INC: begin wd = opd + 8'd1; we = 1'b1; set_nz(wd); end
			ACT_DEC: begin wd = opd - 8'd1; we = 1'b1; set_nz(wd); end
			ACT_INX: begin x_r = x_r + 8'd1; set_nz(x_r); end
			ACT_INY: begin y_r = y_r + 8'd1; set_nz(y_r); end
			ACT_DEX: begin x_r = x_r - 8'd1; set_nz(x_r); end
			ACT_DEY: begin y_r = y_r - 8'd1; set_nz(y_r); end
			ACT_BCC: take = !p_r[FL_C];
			ACT_BCS: take = p_r[FL_C];
			ACT_BEQ: take = p_r[FL_Z];
			ACT_BNE: take = !p_r[FL_Z];
			ACT_BMI: take = p_r[FL_N];
			ACT_BPL: take = !p_r[FL_N];
			ACT_BVC: take = !p_r[FL_V];
			ACT_BVS: take = p_r[FL_V];
			ACT_JMP: pc = it.effective_address;
			ACT_JSR: begin
				ret = it.next_pc - 16'd1;
				stack_push(ret[15:8]);
				stack_push(ret[7:0]);
				pc = it.effective_address;
			end
			ACT_RTS: begin
				lo = stack_pull();
				hi = stack_pull();
				pc = {hi, lo} + 16'd1;
			end
			ACT_BRK: begin
				stack_push(it.next_pc[15:8]);
				stack_push(it.next_pc[7:0]);
				stack_push(p_r | PUSH_MASK);
				p_r[FL_I] = 1'b1;
				pc = brk_vector;
			end
			ACT_RTI: begin
				p_r = stack_pull() & ~PUSH_MASK;
				lo = stack_pull();
				hi = stack_pull();
				pc = {hi, lo};
			end
			default: ;
		endcase
		// Taken branches add the sign-extended offset to the next pc.
		if (take)
			pc = it.next_pc + {{8{opd[7]}}, opd};
		r.new_pc        = pc;
		r.write_enable  = we;
		r.write_address = we ? it.effective_address : 16'h0000;
		r.write_data    = we ? wd : 8'h00;
		r.acc_value     = acc_r;
		r.x_value       = x_r;
		r.y_value       = y_r;
		r.stack_pointer = sp_r;
		r.flags         = p_r;
		return r;
	endfunction

	function automatic in_item_t make_instr(act_t a, logic [7:0] opd, logic [15:0] ea,
			logic on_acc, logic [15:0] npc);
		in_item_t it;
		it.action            = a;
		it.operand           = opd;
		it.effective_address = ea;
		it.on_accumulator    = on_acc;
		it.next_pc           = npc;
		return it;
	endfunction

	function automatic out_item_t make_result(logic [15:0] pc, logic we, logic [15:0] wa,
			logic [7:0] wd, logic [7:0] a, logic [7:0] x, logic [7:0] y,
			logic [7:0] sp, logic [7:0] p);
		out_item_t r;
		r = '{pc, we, wa, wd, a, x, y, sp, p};
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 0;
		else if (pick < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	// Random instruction, weighted towards stack traffic, with some unknown codes; pulls kept within written entries.
	function automatic in_item_t random_instr();
		in_item_t   it;
		int         pick;
		act_t       stack_acts [8];
		logic [5:0] a;
		stack_acts = '{ACT_PHA, ACT_PHP, ACT_PLA, ACT_PLP, ACT_JSR, ACT_RTS, ACT_BRK,
			ACT_RTI};
		pick = $urandom_range(99);
		if (pick < 25)
			a = stack_acts[$urandom_range(7)];
		else if (pick < 33)
			a = 6'($urandom_range(63, 51));
		else
			a = 6'($urandom_range(50));
		case (act_t'(a))
			ACT_PLA, ACT_PLP: if (!pulls_defined(1)) a = ACT_PHA;
			ACT_RTS:          if (!pulls_defined(2)) a = ACT_JSR;
			ACT_RTI:          if (!pulls_defined(3)) a = ACT_BRK;
			default: ;
		endcase
		it.action = a;
		pick = $urandom_range(9);
		it.operand = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
			(pick == 2) ? 8'h80 : (pick == 3) ? 8'h7F : 8'($urandom);
		it.effective_address = 16'($urandom);
		it.on_accumulator    = 1'($urandom);
		it.next_pc           = 16'($urandom);
		return it;
	endfunction

	task automatic send_instr(in_item_t it, bit typed, out_item_t typed_result);
		out_item_t predicted;
		int        gap;
		instr_ch.valid <= 1'b1;
		instr_ch.data  <= it;
		do @(posedge clk); while (!instr_ch.ready);
		predicted = execute_instr(it);
		expected_results.push_back(typed ? typed_result : predicted);
		items_sent++;
		if (act_t'(it.action) inside {ACT_PHA, ACT_PHP, ACT_PLA, ACT_PLP, ACT_JSR,
				ACT_RTS, ACT_BRK, ACT_RTI})
			stack_ops++;
		gap = gap_cycles();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Written only with nothing in flight; the pause covers the back of the pipeline.
	task automatic write_break_vector(logic [15:0] v);
		instr_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		brk_vector = v;
		vector_writes++;
	endtask

	// Receiver back-pressure with short and occasional long stalls, off for one phase.
	always @(posedge clk) begin
		if (!arst_n || !rx_idle_on) begin
			result_ch.ready <= 1'b1;
			rx_hold         <= 0;
		end else if (rx_hold > 0) begin
			result_ch.ready <= 1'b0;
			rx_hold         <= rx_hold - 1;
		end else if ($urandom_range(99) < 25) begin
			result_ch.ready <= 1'b0;
			rx_hold         <= gap_cycles();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expected one.
	always @(posedge clk) begin
		out_item_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.new_pc !== want.new_pc || got.write_enable !== want.write_enable ||
						got.write_address !== want.write_address ||
						got.write_data !== want.write_data ||
						got.acc_value !== want.acc_value || got.x_value !== want.x_value ||
						got.y_value !== want.y_value ||
						got.stack_pointer !== want.stack_pointer ||
						got.flags !== want.flags) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch\n  expected %p\n  actual   %p", want, got);
				end
			end
		end
	end

	// Stimulus.
	initial begin
		stim_row_t rows [$];
		out_item_t none;
		none = '0;
		acc_r = 8'h00; x_r = 8'h00; y_r = 8'h00; sp_r = SP_RESET; p_r = P_RESET;
		brk_vector = 16'h0000;
		foreach (stack_known[i]) stack_known[i] = 1'b0;
		mismatches = 0; items_sent = 0; stack_ops = 0; vector_writes = 0;
		rx_idle_on = 1'b1;
		arst_n = 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.data  <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.data    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: reset state, extremes, most instruction groups, an unknown code and the stack round trips.
		rows.push_back('{make_instr(ACT_NOP, 8'h00, 16'h0000, 1'b0, 16'h1234), 1'b1,
			make_result(16'h1234, 1'b0, 16'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h04)});
		rows.push_back('{make_instr(ACT_LDA, 8'h80, 16'hFFFF, 1'b1, 16'hFFFF), 1'b1,
			make_result(16'hFFFF, 1'b0, 16'h0, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h84)});
		rows.push_back('{make_instr(ACT_LDX, 8'hFF, 16'h0000, 1'b0, 16'h0000), 1'b1,
			make_result(16'h0000, 1'b0, 16'h0, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h84)});
		rows.push_back('{make_instr(ACT_LDY, 8'h00, 16'h0000, 1'b0, 16'h0002), 1'b1,
			make_result(16'h0002, 1'b0, 16'h0, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h06)});
		rows.push_back('{make_instr(ACT_INC, 8'hFF, 16'hBEEF, 1'b0, 16'h0004), 1'b1,
			make_result(16'h0004, 1'b1, 16'hBEEF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF,
				8'h06)});
		rows.push_back('{make_instr(ACT_DEC, 8'h00, 16'hFFFF, 1'b0, 16'h0006), 1'b0, none});
		rows.push_back('{make_instr(ACT_SEC, 8'h00, 16'h0000, 1'b0, 16'h0007), 1'b0, none});
		rows.push_back('{make_instr(ACT_ROR, 8'h01, 16'h0000, 1'b1, 16'h0008), 1'b0, none});
		rows.push_back('{make_instr(ACT_LSR, 8'hFF, 16'h8001, 1'b0, 16'h0009), 1'b0, none});
		rows.push_back('{make_instr(ACT_BIT, 8'hC0, 16'h0000, 1'b0, 16'h000A), 1'b0, none});
		rows.push_back('{make_instr(ACT_BVS, 8'h80, 16'h0000, 1'b0, 16'h0010), 1'b0, none});
		rows.push_back('{make_instr(ACT_BPL, 8'h7F, 16'h0000, 1'b0, 16'hFFF0), 1'b0, none});
		rows.push_back('{make_instr(ACT_SED, 8'h00, 16'h0000, 1'b0, 16'h0020), 1'b0, none});
		rows.push_back('{make_instr(ACT_PHA, 8'h00, 16'h0000, 1'b0, 16'h0021), 1'b0, none});
		rows.push_back('{make_instr(ACT_PHP, 8'h00, 16'h0000, 1'b0, 16'h0022), 1'b0, none});
		rows.push_back('{make_instr(ACT_PLP, 8'h00, 16'h0000, 1'b0, 16'h0023), 1'b0, none});
		rows.push_back('{make_instr(ACT_PLA, 8'h00, 16'h0000, 1'b0, 16'h0024), 1'b0, none});
		rows.push_back('{make_instr(ACT_JSR, 8'h00, 16'h4000, 1'b0, 16'h0000), 1'b0, none});
		rows.push_back('{make_instr(ACT_RTS, 8'h00, 16'h0000, 1'b0, 16'h4001), 1'b0, none});
		rows.push_back('{make_instr(ACT_BRK, 8'h00, 16'h0000, 1'b0, 16'hFFFF), 1'b0, none});
		rows.push_back('{make_instr(ACT_RTI, 8'h00, 16'h0000, 1'b0, 16'h0000), 1'b0, none});
		rows.push_back('{make_instr(ACT_TXS, 8'h00, 16'h0000, 1'b0, 16'h0030), 1'b0, none});
		rows.push_back('{make_instr(ACT_STA, 8'h00, 16'h0100, 1'b0, 16'h0031), 1'b0, none});
		rows.push_back('{make_instr(act_t'(6'd63), 8'hFF, 16'hFFFF, 1'b1, 16'h0032), 1'b0,
			none});
		foreach (rows[i])
			send_instr(rows[i].item, rows[i].typed, rows[i].result);

		// Random phases with a fresh break vector each, one phase without back-pressure.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_break_vector(16'hFFFF);
				1: write_break_vector(16'h0000);
				default: write_break_vector(16'($urandom));
			endcase
			rx_idle_on = (phase != 2);
			for (int n = 0; n < 345; n++)
				send_instr(random_instr(), 1'b0, none);
		end
		instr_ch.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d instructions, %0d of them stack operations,",
			items_sent, stack_ops);
		$display("with %0d break vector settings.", vector_writes);
		$display("Mismatches counted: %0d", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog.
	initial begin
		#5000000;
		$display("Timed out with %0d results outstanding.", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== cpu8_execute_unit.f =====
+incdir+hw/rtl
hw/rtl/cpu8eu_pkg.sv
hw/rtl/cpu8eu_chan_if.sv
hw/rtl/cpu8eu_front.sv
hw/rtl/cpu8eu_back.sv
hw/rtl/cpu8_execute_unit.sv
dv/tb_cpu8_execute_unit.sv
